// ===== sv/sam_pkg.sv =====
// ----------------------------------------------------------------------------
// sam_pkg
// Shared constants for the two-list sort and merge block.
// ----------------------------------------------------------------------------
package sam_pkg;

	localparam int LIST_DEPTH_C = 32;
	localparam int DATA_WIDTH_C = 32;

	// Item kinds on the input channel.
	localparam logic [1:0] KIND_A   = 2'd0;
	localparam logic [1:0] KIND_B   = 2'd1;
	localparam logic [1:0] KIND_END = 2'd2;

endpackage

// ===== sv/sam_ram.sv =====
// ----------------------------------------------------------------------------
// sam_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sam_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/sort_and_merge_two_lists.sv =====
// ----------------------------------------------------------------------------
// sort_and_merge_two_lists
// Collects two lists, keeps each sorted in its own RAM and merges them on
// end of set.
// ----------------------------------------------------------------------------
// Element transactions: an element for an empty list is written straight
// in; otherwise a read-compare-shift loop on one RAM moves entries up to
// open the hole for it. End of set: each result takes a RAM read, then a
// compare and load of the output register, which waits while it is full.
// Reset: arst_n clears counts, the overflow flag, the state and the output
// valid; RAM contents are not cleared and unwritten entries are never used.
module sort_and_merge_two_lists
	import sam_pkg::*;
#(
	parameter int LIST_DEPTH = LIST_DEPTH_C,
	parameter int DATA_WIDTH = DATA_WIDTH_C
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         kind,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] value_res,
	output logic               source,
	output logic               last,
	output logic               empty_res,
	output logic               overflow
);

	localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int CW = $clog2(LIST_DEPTH + 1);
	localparam logic [CW-1:0] FULL = CW'(LIST_DEPTH);

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_INS_RD  = 3'd1;
	localparam logic [2:0] ST_INS_CMP = 3'd2;
	localparam logic [2:0] ST_INS_WR  = 3'd3;
	localparam logic [2:0] ST_MRD     = 3'd4;
	localparam logic [2:0] ST_MCMP    = 3'd5;

	logic [2:0]                  state_q;
	logic [CW-1:0]               count_a_q, count_b_q;
	logic [CW-1:0]               ia_q, ib_q;
	logic [CW-1:0]               pos_q;      // hole position during insertion
	logic                        sel_q;      // list being inserted into, 1 is B
	logic signed [DATA_WIDTH-1:0] key_q;
	logic                        dropped_q;

	logic                        out_valid_q;
	logic signed [31:0]          value_res_q;
	logic                        source_q, last_q, empty_q, overflow_q;

	// RAM ports
	logic                        we_a, we_b;
	logic [AW-1:0]               waddr, raddr_a, raddr_b;
	logic signed [DATA_WIDTH-1:0] wdata, rdata_a, rdata_b, rdata_sel;
	logic [CW-1:0]               pos_m1;

	logic signed [DATA_WIDTH-1:0] value_n;
	logic                        in_fire, out_free, key_less, take_a;
	logic [CW:0]                 total, emitted;

	sam_ram #(.WIDTH(DATA_WIDTH), .DEPTH(LIST_DEPTH)) u_ram_a (
		.clk(clk), .we(we_a), .waddr(waddr), .wdata(wdata),
		.raddr(raddr_a), .rdata(rdata_a)
	);

	sam_ram #(.WIDTH(DATA_WIDTH), .DEPTH(LIST_DEPTH)) u_ram_b (
		.clk(clk), .we(we_b), .waddr(waddr), .wdata(wdata),
		.raddr(raddr_b), .rdata(rdata_b)
	);

	// The input is taken only while idle and with the output register empty,
	// so an end-of-set transaction can always place its first result.
	assign in_ready = (state_q == ST_IDLE) && !out_valid_q;
	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	assign value_n   = DATA_WIDTH'(value);
	assign pos_m1    = pos_q - CW'(1);
	assign rdata_sel = sel_q ? rdata_b : rdata_a;
	assign key_less  = key_q < rdata_sel;

	// During insertion the selected list reads the entry below the hole;
	// during merge each list reads its own head.
	always_comb begin
		raddr_a = ia_q[AW-1:0];
		raddr_b = ib_q[AW-1:0];
		if (state_q == ST_INS_RD) begin
			if (sel_q) begin
				raddr_b = pos_m1[AW-1:0];
			end else begin
				raddr_a = pos_m1[AW-1:0];
			end
		end
	end

	// Write side: shift an entry up into the hole, or drop the key into it.
	always_comb begin
		logic wr;
		wr    = 1'b0;
		waddr = pos_q[AW-1:0];
		wdata = key_q;
		case (state_q)
			ST_INS_CMP: begin
				wr = 1'b1;
				if (key_less) begin
					wdata = rdata_sel;
				end
			end
			ST_INS_WR: begin
				wr = 1'b1;
			end
			default: begin
				wr = 1'b0;
			end
		endcase
		we_a = wr && !sel_q;
		we_b = wr && sel_q;
	end

	// Merge choice: B goes first on equal heads.
	assign total   = {1'b0, count_a_q} + {1'b0, count_b_q};
	assign emitted = {1'b0, ia_q} + {1'b0, ib_q};
	assign take_a  = (ia_q < count_a_q) && ((ib_q >= count_b_q) || (rdata_a < rdata_b));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_a_q   <= '0;
			count_b_q   <= '0;
			ia_q        <= '0;
			ib_q        <= '0;
			pos_q       <= '0;
			sel_q       <= 1'b0;
			dropped_q   <= 1'b0;
			out_valid_q <= 1'b0;
			value_res_q <= '0;
			source_q    <= 1'b0;
			last_q      <= 1'b0;
			empty_q     <= 1'b0;
			overflow_q  <= 1'b0;
		end else begin
			// In the merge compare state the output register is reloaded
			// whenever it is drained, so it is not cleared there.
			if (out_valid_q && out_ready && state_q != ST_MCMP) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (kind == KIND_A || kind == KIND_B) begin
							sel_q <= (kind == KIND_B);
							if (kind == KIND_A && count_a_q != FULL) begin
								pos_q     <= count_a_q;
								count_a_q <= count_a_q + CW'(1);
								state_q   <= (count_a_q == '0) ? ST_INS_WR : ST_INS_RD;
							end else if (kind == KIND_B && count_b_q != FULL) begin
								pos_q     <= count_b_q;
								count_b_q <= count_b_q + CW'(1);
								state_q   <= (count_b_q == '0) ? ST_INS_WR : ST_INS_RD;
							end else begin
								dropped_q <= 1'b1;
							end
						end else if (kind == KIND_END) begin
							ia_q <= '0;
							ib_q <= '0;
							if (total == '0) begin
								// Empty set: a single flagged result.
								out_valid_q <= 1'b1;
								value_res_q <= '0;
								source_q    <= 1'b0;
								last_q      <= 1'b1;
								empty_q     <= 1'b1;
								overflow_q  <= dropped_q;
								dropped_q   <= 1'b0;
							end else begin
								state_q <= ST_MRD;
							end
						end
					end
				end
				ST_INS_RD: begin
					state_q <= ST_INS_CMP;
				end
				ST_INS_CMP: begin
					if (key_less) begin
						pos_q   <= pos_m1;
						state_q <= (pos_m1 == '0) ? ST_INS_WR : ST_INS_RD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_INS_WR: begin
					state_q <= ST_IDLE;
				end
				ST_MRD: begin
					state_q <= ST_MCMP;
				end
				ST_MCMP: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						value_res_q <= 32'(take_a ? rdata_a : rdata_b);
						source_q    <= !take_a;
						last_q      <= (emitted + (CW+1)'(1)) == total;
						empty_q     <= 1'b0;
						overflow_q  <= dropped_q;
						if (take_a) begin
							ia_q <= ia_q + CW'(1);
						end else begin
							ib_q <= ib_q + CW'(1);
						end
						if ((emitted + (CW+1)'(1)) == total) begin
							count_a_q <= '0;
							count_b_q <= '0;
							dropped_q <= 1'b0;
							state_q   <= ST_IDLE;
						end else begin
							state_q <= ST_MRD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Key register needs no reset: it is loaded with every element taken.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			key_q <= value_n;
		end
	end

	assign out_valid = out_valid_q;
	assign value_res = value_res_q;
	assign source    = source_q;
	assign last      = last_q;
	assign empty_res = empty_q;
	assign overflow  = overflow_q;

endmodule

// ===== verif/tb_sort_and_merge_two_lists.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sort_and_merge_two_lists
// Self-checking testbench for the two-list sort and merge block. Directed
// rows cover empty sets, extremes, ties and the unused kind, then full lists;
// random sets with random idling on both channels follow. Every result is
// compared field by field against a behavioral predictor of the block.
// ----------------------------------------------------------------------------
module tb_sort_and_merge_two_lists;
	import sam_pkg::*;

	localparam int DEPTH = LIST_DEPTH_C;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	// One merged result as the block presents it.
	typedef struct packed {
		logic signed [31:0] val;
		logic               src;
		logic               lst;
		logic               emp;
		logic               ovf;
	} merged_t;

	// One row of the directed table. When has_exp is set the row also carries
	// the single result that it must produce, typed in by hand.
	typedef struct {
		logic [1:0]         k;
		logic signed [31:0] v;
		bit                 has_exp;
		merged_t            exp;
	} dir_row_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [1:0]         kind;
	logic signed [31:0] value;
	logic               out_valid;
	logic               out_ready;
	logic signed [31:0] value_res;
	logic               source;
	logic               last;
	logic               empty_res;
	logic               overflow;

	// Predictor state: the two lists as held so far, and the drop flag.
	logic signed [31:0] list_a[$];
	logic signed [31:0] list_b[$];
	bit                 dropped;

	// Results still owed by the block, oldest first.
	merged_t pending_results[$];

	int errors;
	int results_seen;
	int sets_sent;
	int items_sent;
	int send_idle_pct;
	int recv_idle_pct;
	bit hold_off;

	sort_and_merge_two_lists uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .kind(kind), .value(value),
		.out_valid(out_valid), .out_ready(out_ready),
		.value_res(value_res), .source(source), .last(last),
		.empty_res(empty_res), .overflow(overflow)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Plain insertion sort, ascending by signed value.
	function automatic void sort_ascending(ref logic signed [31:0] q[$]);
		logic signed [31:0] key;
		int j;
		for (int i = 1; i < q.size(); i++) begin
			key = q[i];
			j = i;
			while (j > 0 && key < q[j-1]) begin
				q[j] = q[j-1];
				j--;
			end
			q[j] = key;
		end
	endfunction

	// Updates the predicted lists for one accepted transaction and, on end of
	// set, pushes the merged results it must cause.
	function automatic void predict_merge(logic [1:0] k, logic signed [31:0] v);
		merged_t r;
		int total;
		int ia;
		int ib;
		ia = 0;
		ib = 0;
		if (k == KIND_A) begin
			if (list_a.size() < DEPTH) list_a.push_back(v);
			else dropped = 1'b1;
		end else if (k == KIND_B) begin
			if (list_b.size() < DEPTH) list_b.push_back(v);
			else dropped = 1'b1;
		end else if (k == KIND_END) begin
			total = list_a.size() + list_b.size();
			if (total == 0) begin
				r = '{val: 0, src: 1'b0, lst: 1'b1, emp: 1'b1, ovf: dropped};
				pending_results.push_back(r);
			end else begin
				sort_ascending(list_a);
				sort_ascending(list_b);
				for (int n = 0; n < total; n++) begin
					// A goes first only when strictly smaller; ties go to B.
					if (ia < list_a.size() &&
					    (ib >= list_b.size() || list_a[ia] < list_b[ib])) begin
						r.val = list_a[ia++];
						r.src = 1'b0;
					end else begin
						r.val = list_b[ib++];
						r.src = 1'b1;
					end
					r.lst = (n == total - 1);
					r.emp = 1'b0;
					r.ovf = dropped;
					pending_results.push_back(r);
				end
			end
			list_a.delete();
			list_b.delete();
			dropped = 1'b0;
			sets_sent++;
		end
		// The unused kind leaves everything as it is.
	endfunction

	// Offers one transaction, holding it until the block accepts it. A random
	// gap may come first, depending on the sender's idle rate. Valid stays high
	// after acceptance so that a following call can offer its item at once.
	task automatic send_item(input logic [1:0] k, input logic signed [31:0] v);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind     <= k;
		value    <= v;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_merge(k, v);
		items_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// Receiver: random ready, plus a long hold-off on request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Checker: compares every accepted result with the oldest expectation.
	always @(posedge clk) begin
		merged_t e;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				$error("Unexpected result transaction: value_res %0d", value_res);
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (value_res !== e.val) begin
					$error("value_res: expected %0d, got %0d", e.val, value_res);
					errors++;
				end
				if (source !== e.src) begin
					$error("source: expected %0b, got %0b", e.src, source);
					errors++;
				end
				if (last !== e.lst) begin
					$error("last: expected %0b, got %0b", e.lst, last);
					errors++;
				end
				if (empty_res !== e.emp) begin
					$error("empty_res: expected %0b, got %0b", e.emp, empty_res);
					errors++;
				end
				if (overflow !== e.ovf) begin
					$error("overflow: expected %0b, got %0b", e.ovf, overflow);
					errors++;
				end
			end
		end
	end

	// Random value with a bias toward extremes and small numbers, so that
	// ties between and within the lists show up often.
	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(5))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2, 3: return $signed(32'($urandom_range(8))) - 4;
			default: return $signed($urandom());
		endcase
	endfunction

	// One random set: elements for both lists, some noise, then end of set.
	// Most sets are small; now and then one carries more elements than a list holds.
	task automatic send_random_set();
		int n;
		int r;
		r = $urandom_range(99);
		if (r < 5) n = 0;
		else if (r < 12) n = DEPTH + 4 + $urandom_range(8);
		else n = 1 + $urandom_range(9);
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 3) send_item(KIND_UNUSED, $signed($urandom()));
			else if (r < 51) send_item(KIND_A, pick_value());
			else send_item(KIND_B, pick_value());
		end
		send_item(KIND_END, $signed($urandom()));
	endtask

	dir_row_t dir_table[$];

	function automatic dir_row_t row(logic [1:0] k, logic signed [31:0] v);
		row = '{k: k, v: v, has_exp: 1'b0, exp: '0};
	endfunction

	function automatic dir_row_t row_exp(logic [1:0] k, merged_t e);
		row_exp = '{k: k, v: 32'sd0, has_exp: 1'b1, exp: e};
	endfunction

	initial begin
		int mark;
		int phase_sets;
		errors        = 0;
		results_seen  = 0;
		sets_sent     = 0;
		items_sent    = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_off      = 1'b0;
		dropped       = 1'b0;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		kind          = KIND_A;
		value         = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table. An empty set right after reset and single-element
		// sets at the extremes have results that can be written down directly.
		dir_table.push_back(row_exp(KIND_END, '{0, 1'b0, 1'b1, 1'b1, 1'b0}));
		dir_table.push_back(row(KIND_A, 32'sh7fffffff));
		dir_table.push_back(row_exp(KIND_END, '{32'sh7fffffff, 1'b0, 1'b1, 1'b0, 1'b0}));
		dir_table.push_back(row(KIND_B, 32'sh80000000));
		dir_table.push_back(row_exp(KIND_END, '{32'sh80000000, 1'b1, 1'b1, 1'b0, 1'b0}));
		// The unused kind changes nothing, so this set is still empty.
		dir_table.push_back(row(KIND_UNUSED, 32'sh5a5a5a5a));
		dir_table.push_back(row_exp(KIND_END, '{0, 1'b0, 1'b1, 1'b1, 1'b0}));
		// Ties across lists go to B first, extremes on both sides, and
		// duplicates inside one list.
		dir_table.push_back(row(KIND_A, 32'sd5));
		dir_table.push_back(row(KIND_A, 32'sh80000000));
		dir_table.push_back(row(KIND_B, 32'sd5));
		dir_table.push_back(row(KIND_B, 32'sh7fffffff));
		dir_table.push_back(row(KIND_A, -32'sd1));
		dir_table.push_back(row(KIND_B, -32'sd1));
		dir_table.push_back(row(KIND_A, 32'sh7fffffff));
		dir_table.push_back(row(KIND_B, 32'sd0));
		dir_table.push_back(row(KIND_A, 32'sd5));
		dir_table.push_back(row(KIND_B, 32'sh55555555));
		dir_table.push_back(row(KIND_A, 32'shaaaaaaaa));
		dir_table.push_back(row(KIND_END, 32'sd0));

		foreach (dir_table[i]) begin
			send_item(dir_table[i].k, dir_table[i].v);
			// Rows with a typed-in result replace the predicted one.
			if (dir_table[i].has_exp) begin
				if (pending_results.size() != 0) void'(pending_results.pop_back());
				pending_results.push_back(dir_table[i].exp);
			end
		end

		// Full lists: both lists filled past depth, then end of set; the
		// results carry the overflow flag.
		for (int i = 0; i < DEPTH + 2; i++) send_item(KIND_A, 32'(DEPTH - i));
		for (int i = 0; i < DEPTH + 1; i++) send_item(KIND_B, 32'(i));
		send_item(KIND_END, 32'sd0);
		wait_drained();

		// Random phases: sender idles rarely and receiver often, then the
		// other way round, then no idling at all.
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 8 : (phase == 1) ? 74 : 0;
			recv_idle_pct = (phase == 0) ? 74 : (phase == 1) ? 8 : 0;
			phase_sets = 0;
			mark = items_sent;
			while (items_sent - mark < 40) begin
				send_random_set();
				phase_sets++;
				// Sender pause: wait for every expected result now and then.
				if (phase_sets % 6 == 0) wait_drained();
			end
		end

		// Back-pressure: the receiver holds off for a long stretch while random
		// sets and more items are offered, so the block stalls its input.
		recv_idle_pct = 0;
		send_idle_pct = 0;
		fork
			begin
				hold_off = 1'b1;
				repeat (600) @(posedge clk);
				hold_off = 1'b0;
			end
			begin
				for (int i = 0; i < 3; i++) send_random_set();
				for (int i = 0; i < 10; i++) send_item(KIND_B, pick_value());
				send_item(KIND_END, 32'sd0);
				in_valid <= 1'b0;
			end
		join

		wait_drained();
		repeat (200) @(posedge clk);

		$display("Covered %0d transactions in %0d sets, %0d results checked,",
			items_sent, sets_sent, results_seen);
		$display("with ties, extremes, empty sets, full lists and back-pressure.");
		if (errors == 0 && pending_results.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// Overall time limit, well above the slowest correct run.
	initial begin
		#20ms;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
